// File: rtl/pss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pss_pkg;

    localparam int MAX_STEPS_DEF = 256;

    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 80;
    localparam int CFG_W      = 24;

    localparam int PTR_W  = 9;
    localparam int DIST_W = 16;
    localparam int ANG_W  = 10;
    localparam int DT_W   = 20;
    localparam int TRAV_W = 24;
    localparam int NSD_W  = 25;
    localparam int HEAD_W = 27;
    localparam int ERR_W  = 27;
    localparam int EL_W   = 32;
    localparam int DIR_W  = 8;
    localparam int PROD_W = 52;
    localparam int CNT_W  = 5;

    localparam logic signed [HEAD_W-1:0] HEAD_MAX = 27'sd47185920;
    localparam logic signed [27:0] HALF_TURN = 28'sd11796480;
    localparam logic signed [27:0] FULL_TURN = 28'sd23592960;
    localparam logic signed [29:0] DIR_LIMIT = 30'sd5242880;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TICK = 1'b1;

endpackage

`default_nettype wire

// File: rtl/pss_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module pss_ram
    import pss_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
)
(
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: rtl/path_step_steering_sequencer_core.sv
// path step steering sequencer
// input stream s_axis: tuser selects the word kind (0 load one path step, 1 tick),
// tlast on a load marks the final step and arms the path; tdata fields below.
// output stream m_axis: exactly one result word per accepted input word.
// config channel cfg_valid/cfg_ready/cfg_data writes turn_rate; always ready.
// sequence: a load goes from idle to its result register; a tick passes the arm
// check and the main step, then the memory wait, set and scale states when it moves
// to a new step (arming adds the fetch of step 0), and when the heading is integrated
// the bit-serial multiplier (steering magnitude, then delta time), heading and compare.
// one word is in work at a time; the next word is taken as soon as the engine
// is back in idle, which it reaches as the previous result enters the output
// register, even while that result still waits there. if the receiver stalls
// with a result pending, a finished result waits in the engine and the input
// side stops until the output register frees.
// reset clears all control state, the path length, pointer, heading and counter;
// the step memory is not cleared and must be loaded before a path is armed.
`timescale 1ns / 1ps
`default_nettype none

module path_step_steering_sequencer_core
    import pss_pkg::*;
#(
    parameter int MAX_STEPS = MAX_STEPS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // step_index, step_distance_mm, step_angle_deg, delta_time_us,
    // distance_traveled_mm, moving_in, manual_mode, direction_in
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // req_type
    input  wire logic                  s_axis_tuser,
    input  wire logic                  s_axis_tlast,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // direction_out, moving_out, path_active, step_number, current_angle,
    // step_elapsed_us, zero pad
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_W-1:0]      cfg_data
);

    localparam int AW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_ARM    = 10'b0000000010,
        S_RDWAIT = 10'b0000000100,
        S_SET    = 10'b0000001000,
        S_SCALE  = 10'b0000010000,
        S_MAIN   = 10'b0000100000,
        S_MUL    = 10'b0001000000,
        S_HEAD   = 10'b0010000000,
        S_CMP    = 10'b0100000000,
        S_DONE   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic [CFG_W-1:0]         turn_rate_reg;
    logic [PTR_W-1:0]         plen_reg;
    logic                     pend_reg;
    logic                     follow_reg;
    logic [PTR_W-1:0]         ptr_reg;
    logic [NSD_W-1:0]         nsd_reg;
    logic signed [ANG_W-1:0]  th_reg;
    logic signed [HEAD_W-1:0] head_reg;
    logic [ERR_W-1:0]         perr_reg;
    logic [EL_W-1:0]          el_reg;

    logic [DT_W-1:0]          dt_reg;
    logic [TRAV_W-1:0]        trav_reg;
    logic                     moving_reg;
    logic                     manual_reg;
    logic signed [DIR_W-1:0]  dir_reg;
    logic                     arm_reg;
    logic signed [27:0]       derr_reg;

    logic [PROD_W-1:0]        mcand_reg;
    logic [PROD_W-1:0]        acc_reg;
    logic [DT_W-1:0]          mplier_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic                     phase_reg;

    logic                     out_valid_reg;
    logic [OUT_DATA_W-1:0]    out_data_reg;

    // input fields
    logic [7:0]               in_idx;
    logic [DIST_W-1:0]        in_dist;
    logic [ANG_W-1:0]         in_ang;

    assign in_idx  = s_axis_tdata[7:0];
    assign in_dist = s_axis_tdata[23:8];
    assign in_ang  = s_axis_tdata[33:24];

    logic                     accept;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    // step memory
    logic                       ram_we;
    logic [12:0]                idx_ext;
    logic [12:0]                ptr_ext;
    logic [AW-1:0]              ram_raddr;
    logic [DIST_W+ANG_W-1:0]    ram_rdata;
    logic [DIST_W-1:0]          rd_dist;
    logic signed [ANG_W-1:0]    rd_ang;

    assign idx_ext   = {5'b0, in_idx};
    assign ptr_ext   = {4'b0, ptr_reg};
    assign ram_we    = accept && (s_axis_tuser == REQ_LOAD) && (32'(in_idx) < MAX_STEPS);
    assign ram_raddr = (32'(ptr_reg) < MAX_STEPS) ? ptr_ext[AW-1:0] : '0;
    assign rd_dist   = ram_rdata[DIST_W-1:0];
    assign rd_ang    = $signed(ram_rdata[DIST_W+ANG_W-1:DIST_W]);

    pss_ram #(
        .WIDTH (DIST_W + ANG_W),
        .DEPTH (MAX_STEPS)
    ) u_step_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_ext[AW-1:0]),
        .wdata ({in_ang, in_dist}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // combinational datapath pieces
    logic signed [HEAD_W-1:0] tq_new;
    logic signed [HEAD_W-1:0] tq_cur;
    logic signed [27:0]       d_raw;
    logic signed [27:0]       d_wrap;
    logic [NSD_W-1:0]         nsd_new;
    logic signed [29:0]       d_ext;
    logic signed [29:0]       d_scaled;
    logic signed [29:0]       d_clamp;
    logic signed [29:0]       d_neg;
    logic signed [DIR_W-1:0]  dir_set;
    logic [32:0]              el_sum;
    logic [PTR_W:0]           ptr_inc;
    logic [7:0]               dir_mag;
    logic [PROD_W-1:0]        acc_add;
    logic signed [PROD_W:0]   sprod;
    logic signed [55:0]       full;
    logic signed [47:0]       nh;
    logic signed [HEAD_W-1:0] nh_sat;
    logic signed [27:0]       cmp_diff;
    logic [27:0]              cmp_abs;

    assign tq_new  = HEAD_W'({{1{rd_ang[ANG_W-1]}}, rd_ang, 16'b0});
    assign tq_cur  = HEAD_W'({{1{th_reg[ANG_W-1]}}, th_reg, 16'b0});
    assign nsd_new = NSD_W'(trav_reg) + NSD_W'(rd_dist);
    assign d_raw   = 28'(head_reg) - 28'(tq_new);

    always_comb
    begin
        if (d_raw > HALF_TURN)
        begin
            d_wrap = d_raw - FULL_TURN;
        end
        else if (d_raw < -HALF_TURN)
        begin
            d_wrap = d_raw + FULL_TURN;
        end
        else
        begin
            d_wrap = d_raw;
        end
    end

    assign d_ext = 30'(derr_reg);

    always_comb
    begin
        if (nsd_reg < NSD_W'(5))
        begin
            d_scaled = d_ext + (d_ext <<< 1);
        end
        else if (nsd_reg < NSD_W'(10))
        begin
            d_scaled = d_ext <<< 1;
        end
        else
        begin
            d_scaled = d_ext;
        end
        if (d_scaled > DIR_LIMIT)
        begin
            d_clamp = DIR_LIMIT;
        end
        else if (d_scaled < -DIR_LIMIT)
        begin
            d_clamp = -DIR_LIMIT;
        end
        else
        begin
            d_clamp = d_scaled;
        end
        d_neg = -d_clamp;
        if (d_clamp >= 0)
        begin
            dir_set = DIR_W'(d_clamp >>> 16);
        end
        else
        begin
            dir_set = -DIR_W'(d_neg >>> 16);
        end
    end

    assign el_sum  = 33'(el_reg) + 33'(dt_reg);
    assign ptr_inc = 10'(ptr_reg) + 10'd1;
    assign dir_mag = dir_reg[DIR_W-1] ? 8'(-dir_reg) : 8'(dir_reg);
    assign acc_add = mplier_reg[0] ? acc_reg + mcand_reg : acc_reg;

    assign sprod = dir_reg[DIR_W-1] ? -$signed({1'b0, acc_reg}) : $signed({1'b0, acc_reg});
    assign full  = ($signed(56'(head_reg)) <<< 8) - 56'(sprod) + 56'sd128;
    assign nh    = 48'(full >>> 8);

    always_comb
    begin
        if (nh > 48'(HEAD_MAX))
        begin
            nh_sat = HEAD_MAX;
        end
        else if (nh < -48'(HEAD_MAX))
        begin
            nh_sat = -HEAD_MAX;
        end
        else
        begin
            nh_sat = HEAD_W'(nh);
        end
    end

    assign cmp_diff = 28'(tq_cur) - 28'(head_reg);
    assign cmp_abs  = cmp_diff[27] ? 28'(-cmp_diff) : 28'(cmp_diff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            turn_rate_reg <= '0;
            plen_reg      <= '0;
            pend_reg      <= 1'b0;
            follow_reg    <= 1'b0;
            ptr_reg       <= '0;
            nsd_reg       <= '0;
            th_reg        <= '0;
            head_reg      <= '0;
            perr_reg      <= '0;
            el_reg        <= '0;
            out_valid_reg <= 1'b0;
            arm_reg       <= 1'b0;
            phase_reg     <= 1'b0;
            cnt_reg       <= '0;
            derr_reg      <= '0;
            mcand_reg     <= '0;
            acc_reg       <= '0;
            mplier_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                turn_rate_reg <= cfg_data;
            end
            if (state_reg == S_DONE && (!out_valid_reg || m_axis_tready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tvalid && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept && s_axis_tuser == REQ_LOAD && ram_we && s_axis_tlast)
                    begin
                        plen_reg <= PTR_W'(in_idx) + PTR_W'(1);
                        pend_reg <= 1'b1;
                    end
                end
                S_ARM:
                begin
                    if (pend_reg)
                    begin
                        pend_reg <= 1'b0;
                        if (plen_reg != '0)
                        begin
                            ptr_reg    <= '0;
                            follow_reg <= 1'b1;
                            arm_reg    <= 1'b1;
                        end
                    end
                end
                S_RDWAIT:
                begin
                end
                S_SET:
                begin
                    nsd_reg  <= nsd_new;
                    th_reg   <= rd_ang;
                    el_reg   <= '0;
                    derr_reg <= d_wrap;
                    if (ptr_reg == '0)
                    begin
                        head_reg <= tq_new;
                        arm_reg  <= 1'b0;
                    end
                    else
                    begin
                        perr_reg <= ERR_W'(d_raw[27] ? -d_raw : d_raw);
                    end
                end
                S_SCALE:
                begin
                    arm_reg <= 1'b0;
                end
                S_MAIN:
                begin
                    if (!manual_reg && moving_reg && follow_reg)
                    begin
                        el_reg <= el_sum[32] ? '1 : el_sum[EL_W-1:0];
                        if (trav_reg >= TRAV_W'(nsd_reg) && nsd_reg[NSD_W-1] == 1'b0)
                        begin
                            if (ptr_inc >= 10'(plen_reg))
                            begin
                                ptr_reg    <= plen_reg;
                                follow_reg <= 1'b0;
                            end
                            else
                            begin
                                ptr_reg <= ptr_inc[PTR_W-1:0];
                            end
                        end
                        else if (dir_reg != '0)
                        begin
                            mcand_reg  <= PROD_W'(turn_rate_reg);
                            mplier_reg <= DT_W'(dir_mag);
                            acc_reg    <= '0;
                            cnt_reg    <= CNT_W'(DIR_W - 1);
                            phase_reg  <= 1'b0;
                        end
                    end
                end
                S_MUL:
                begin
                    if (cnt_reg == '0 && !phase_reg)
                    begin
                        mcand_reg  <= acc_add;
                        mplier_reg <= dt_reg;
                        acc_reg    <= '0;
                        cnt_reg    <= CNT_W'(DT_W - 1);
                        phase_reg  <= 1'b1;
                    end
                    else
                    begin
                        cnt_reg    <= cnt_reg - CNT_W'(1);
                        acc_reg    <= acc_add;
                        mcand_reg  <= mcand_reg << 1;
                        mplier_reg <= mplier_reg >> 1;
                    end
                end
                S_HEAD:
                begin
                    head_reg <= nh_sat;
                end
                S_CMP:
                begin
                    if (cmp_abs > 28'(perr_reg))
                    begin
                        head_reg <= tq_cur;
                    end
                    else
                    begin
                        perr_reg <= cmp_abs[ERR_W-1:0];
                    end
                end
                S_DONE:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    // per-word payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dt_reg     <= s_axis_tdata[53:34];
            trav_reg   <= s_axis_tdata[77:54];
            moving_reg <= s_axis_tdata[78];
            manual_reg <= s_axis_tdata[79];
            dir_reg    <= $signed(s_axis_tdata[87:80]);
        end
        else
        begin
            unique case (state_reg)
                S_SET:
                begin
                    if (ptr_reg == '0)
                    begin
                        dir_reg <= '0;
                    end
                end
                S_SCALE:
                begin
                    dir_reg <= dir_set;
                end
                S_MAIN:
                begin
                    if (!manual_reg)
                    begin
                        if (!follow_reg)
                        begin
                            moving_reg <= 1'b0;
                        end
                        else if (moving_reg && trav_reg >= TRAV_W'(nsd_reg)
                                 && nsd_reg[NSD_W-1] == 1'b0 && ptr_inc >= 10'(plen_reg))
                        begin
                            moving_reg <= 1'b0;
                        end
                    end
                end
                S_CMP:
                begin
                    if (cmp_abs > 28'(perr_reg))
                    begin
                        dir_reg <= '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (state_reg == S_DONE && (!out_valid_reg || m_axis_tready))
        begin
            out_data_reg <= {2'b0, el_reg, head_reg, ptr_reg, follow_reg,
                             moving_reg, dir_reg};
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (s_axis_tuser == REQ_TICK) ? S_ARM : S_DONE;
                end
            end
            S_ARM:
            begin
                state_next = (pend_reg && plen_reg != '0) ? S_RDWAIT : S_MAIN;
            end
            S_RDWAIT:
            begin
                state_next = S_SET;
            end
            S_SET:
            begin
                if (ptr_reg != '0)
                begin
                    state_next = S_SCALE;
                end
                else
                begin
                    state_next = arm_reg ? S_MAIN : S_DONE;
                end
            end
            S_SCALE:
            begin
                state_next = arm_reg ? S_MAIN : S_DONE;
            end
            S_MAIN:
            begin
                state_next = S_DONE;
                if (!manual_reg && moving_reg && follow_reg)
                begin
                    if (trav_reg >= TRAV_W'(nsd_reg) && nsd_reg[NSD_W-1] == 1'b0)
                    begin
                        state_next = (ptr_inc >= 10'(plen_reg)) ? S_DONE : S_RDWAIT;
                    end
                    else if (dir_reg != '0)
                    begin
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                if (cnt_reg == '0 && phase_reg)
                begin
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    a_follow_has_path: assert property (@(posedge clk) disable iff (!rst_n)
        follow_reg |-> plen_reg != '0)
        else $error("following without a loaded path");

    a_write_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> state_reg == S_IDLE)
        else $error("step memory written outside idle");

    a_head_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_HEAD |-> $past(state_reg) == S_MUL && $past(phase_reg))
        else $error("heading update without finished product");

    a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SET |-> ptr_reg < plen_reg)
        else $error("step fetch beyond path end");

endmodule

`default_nettype wire

// File: tb/sv/tb_path_step_steering_sequencer_core.sv
`timescale 1ns / 1ps

module tb_path_step_steering_sequencer_core;
    import pss_pkg::*;

    typedef struct packed {
        logic [7:0]  steer;
        logic        moving;
        logic        active;
        logic [8:0]  step;
        logic [26:0] heading;
        logic [31:0] elapsed;
    } steer_result_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata;
    logic s_axis_tuser;
    logic s_axis_tlast;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_W-1:0] cfg_data;

    path_step_steering_sequencer_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    // predictor state
    logic [15:0] dist_mem [256];
    logic signed [9:0] ang_mem [256];
    bit written [256];
    int plen;
    bit pend;
    bit follow;
    int sptr;
    longint nsd;
    longint tgt;
    longint head;
    longint perr;
    longint elap;
    longint rate;

    steer_result_t expected_q [$];
    int errors;
    int items;
    int idle_cycles;
    bit calm;
    longint odo;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
            m_axis_tready <= calm || ($urandom_range(99) >= 30);
    end

    always @(posedge clk)
    begin
        steer_result_t got;
        steer_result_t exp_r;
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= 5000)
        begin
            $display("tb: failure");
            $finish;
        end
        else if (m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tdata[7:0], m_axis_tdata[8], m_axis_tdata[9],
                   m_axis_tdata[18:10], m_axis_tdata[45:19], m_axis_tdata[77:46]};
            if (expected_q.size() == 0)
            begin
                $display("%0t unexpected word %h", $time, m_axis_tdata);
                errors++;
            end
            else
            begin
                exp_r = expected_q.pop_front();
                if (got.steer !== exp_r.steer)
                    $display("%0t direction exp %0d got %0d", $time,
                             $signed(exp_r.steer), $signed(got.steer));
                if (got.moving !== exp_r.moving)
                    $display("%0t moving exp %0d got %0d", $time, exp_r.moving, got.moving);
                if (got.active !== exp_r.active)
                    $display("%0t active exp %0d got %0d", $time, exp_r.active, got.active);
                if (got.step !== exp_r.step)
                    $display("%0t step exp %0d got %0d", $time, exp_r.step, got.step);
                if (got.heading !== exp_r.heading)
                    $display("%0t angle exp %0d got %0d", $time,
                             $signed(exp_r.heading), $signed(got.heading));
                if (got.elapsed !== exp_r.elapsed)
                    $display("%0t elapsed exp %0d got %0d", $time, exp_r.elapsed, got.elapsed);
                if (got !== exp_r)
                    errors++;
            end
        end
    end

    task automatic fetch_step(input longint trav, inout longint steer);
        int p;
        longint tq;
        longint d;
        p = sptr < 256 ? sptr : 0;
        nsd = trav + dist_mem[p];
        tgt = ang_mem[p];
        tq = tgt * 65536;
        if (sptr == 0)
        begin
            head = tq;
            steer = 0;
        end
        else
        begin
            d = head - tq;
            if (d > 180 * 65536)
                d -= 360 * 65536;
            else if (d < -180 * 65536)
                d += 360 * 65536;
            if (nsd < 5)
                d *= 3;
            else if (nsd < 10)
                d *= 2;
            if (d > 80 * 65536)
                d = 80 * 65536;
            if (d < -80 * 65536)
                d = -80 * 65536;
            steer = d / 65536;
            perr = (tq - head) < 0 ? head - tq : tq - head;
        end
        elap = 0;
    endtask

    task automatic predict_word(input bit kind, input bit last, input logic [87:0] w);
        int idx;
        longint dt;
        longint trav;
        bit mov;
        bit man;
        longint steer;
        longint prod;
        longint nh;
        longint tq;
        longint diff;
        steer_result_t r;
        idx = w[7:0];
        dt = w[53:34];
        trav = w[77:54];
        mov = w[78];
        man = w[79];
        steer = longint'($signed(w[87:80]));
        if (kind == REQ_LOAD)
        begin
            dist_mem[idx] = w[23:8];
            ang_mem[idx] = w[33:24];
            if (last)
            begin
                plen = idx + 1;
                pend = 1'b1;
            end
        end
        else
        begin
            if (pend)
            begin
                if (plen > 0)
                begin
                    sptr = 0;
                    fetch_step(trav, steer);
                    follow = 1'b1;
                end
                pend = 1'b0;
            end
            if (!man)
            begin
                if (mov && !follow)
                    mov = 1'b0;
                if (mov)
                begin
                    elap = elap + dt;
                    if (elap > 64'hFFFFFFFF)
                        elap = 64'hFFFFFFFF;
                    if (trav >= nsd)
                    begin
                        sptr++;
                        if (sptr >= plen)
                        begin
                            sptr = plen;
                            follow = 1'b0;
                            mov = 1'b0;
                        end
                        else
                            fetch_step(trav, steer);
                    end
                    else if (steer != 0)
                    begin
                        prod = rate * dt * steer;
                        nh = (head * 256 - prod + 128) >>> 8;
                        if (nh > 47185920)
                            nh = 47185920;
                        if (nh < -47185920)
                            nh = -47185920;
                        head = nh;
                        tq = tgt * 65536;
                        diff = (tq - head) < 0 ? head - tq : tq - head;
                        if (diff > perr)
                        begin
                            head = tq;
                            steer = 0;
                        end
                        else
                            perr = diff;
                    end
                end
            end
        end
        r.steer = steer[7:0];
        r.moving = mov;
        r.active = follow;
        r.step = sptr[8:0];
        r.heading = head[26:0];
        r.elapsed = elap[31:0];
        expected_q.push_back(r);
    endtask

    task automatic send_word(input bit kind, input bit last, input logic [87:0] w);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tlast <= last;
        s_axis_tdata <= w;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_word(kind, last, w);
        items++;
        if (!calm && $urandom_range(99) < 30)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
    endtask

    task automatic send_load(input int idx, input int step_dist, input int ang, input bit last);
        logic [87:0] w;
        logic [9:0] a;
        a = 10'(ang);
        w = 88'({$urandom, $urandom, $urandom});
        w[7:0] = 8'(idx);
        w[23:8] = 16'(step_dist);
        w[33:24] = a;
        written[idx] = 1'b1;
        send_word(REQ_LOAD, last, w);
    endtask

    task automatic send_tick(input int dt, input longint trav, input bit mov, input bit man,
                             input int steer);
        logic [87:0] w;
        logic [7:0] s;
        s = 8'(steer);
        w = 88'({$urandom, $urandom, $urandom});
        w[53:34] = 20'(dt);
        w[77:54] = trav[23:0];
        w[78] = mov;
        w[79] = man;
        w[87:80] = s;
        send_word(REQ_TICK, 1'b0, w);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_rate(input longint v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v[23:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        rate = v & 24'hFFFFFF;
    endtask

    function automatic int rand_dist();
        int k;
        k = $urandom_range(99);
        if (k < 80)
            return $urandom_range(12);
        else if (k < 95)
            return $urandom_range(200);
        return $urandom_range(65535);
    endfunction

    function automatic int rand_ang();
        if ($urandom_range(9) == 0)
            return $urandom_range(1) ? 360 : -360;
        return $urandom_range(720) - 360;
    endfunction

    task automatic load_path(input int n);
        for (int i = 0; i < n; i++)
            send_load(i, rand_dist(), rand_ang(), i == n - 1);
    endtask

    task automatic random_tick();
        int k;
        int dt;
        k = $urandom_range(99);
        if (k < 50)
            odo = odo + $urandom_range(6);
        else if (k < 55)
            odo = odo + $urandom_range(300);
        else if (k < 57)
            odo = $urandom_range(24'hFFFFFF);
        dt = ($urandom_range(19) == 0) ? 20'hFFFFF : $urandom_range(3000);
        send_tick(dt, odo, $urandom_range(9) != 0, $urandom_range(9) == 0,
                  $signed(8'($urandom)));
    endtask

    task automatic test_no_path();
        send_tick(100, 0, 1'b1, 1'b0, 5);
        send_tick(20'hFFFFF, 24'hFFFFFF, 1'b1, 1'b1, -128);
        send_tick(0, 0, 1'b0, 1'b0, 127);
    endtask

    task automatic test_directed_path();
        write_rate(24'd65536);
        odo = 0;
        send_load(0, 2, 360, 1'b0);
        send_load(1, 1, -100, 1'b0);
        send_load(2, 5, -360, 1'b0);
        send_load(3, 65535, 170, 1'b0);
        send_load(4, 0, 0, 1'b1);
        send_tick(10, 0, 1'b1, 1'b1, 0);
        send_tick(10, 0, 1'b1, 1'b0, 0);
        send_tick(10, 2, 1'b1, 1'b0, 0);
        send_tick(10, 3, 1'b1, 1'b0, 0);
        send_tick(50, 8, 1'b1, 1'b0, 0);
        send_tick(30, 9, 1'b1, 1'b0, 40);
        send_tick(30, 9, 1'b1, 1'b0, -40);
        send_tick(20'hFFFFF, 9, 1'b1, 1'b0, 127);
        send_tick(10, 65544, 1'b1, 1'b0, 0);
        send_tick(10, 65544, 1'b1, 1'b0, 0);
        send_tick(10, 65544, 1'b1, 1'b0, 3);
    endtask

    task automatic test_full_path();
        write_rate(24'hFFFFFF);
        load_path(256);
        odo = 24'hFFFF00;
        for (int i = 0; i < 60; i++)
            random_tick();
    endtask

    task automatic test_elapsed_long();
        write_rate(0);
        calm = 1'b1;
        send_load(0, 65535, 10, 1'b1);
        send_tick(0, 0, 1'b1, 1'b0, 0);
        for (int i = 0; i < 400; i++)
            send_tick(20'hFFFFF, 0, 1'b1, 1'b0, 0);
        calm = 1'b0;
    endtask

    task automatic test_random();
        int n;
        int idx;
        bool_loop: while (items < 1900)
        begin
            if ($urandom_range(7) == 0)
                case ($urandom_range(3))
                    0: write_rate(0);
                    1: write_rate(24'hFFFFFF);
                    default: write_rate($urandom_range(1 << $urandom_range(22)));
                endcase
            calm = ($urandom_range(9) == 0);
            n = ($urandom_range(9) == 0) ? $urandom_range(40, 1) : $urandom_range(6, 1);
            if ($urandom_range(4) == 0)
                random_tick();
            if ($urandom_range(5) == 0)
                send_load($urandom_range(n), rand_dist(), rand_ang(), 1'b0);
            if ($urandom_range(9) != 0)
                load_path(n);
            repeat ($urandom_range(30, 5))
            begin
                random_tick();
                if ($urandom_range(29) == 0)
                begin
                    idx = $urandom_range(255);
                    if (written[idx] && (idx == 0 || written[idx - 1]))
                    begin
                        for (int j = 0; j < idx; j++)
                            if (!written[j])
                                idx = -1;
                        if (idx >= 0)
                            send_load(idx, rand_dist(), rand_ang(), $urandom_range(1));
                    end
                end
            end
        end
        calm = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        plen = 0;
        pend = 0;
        follow = 0;
        sptr = 0;
        nsd = 0;
        tgt = 0;
        head = 0;
        perr = 0;
        elap = 0;
        rate = 0;
        errors = 0;
        items = 0;
        idle_cycles = 0;
        calm = 1'b0;
        odo = 0;
        for (int i = 0; i < 256; i++)
            written[i] = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_no_path();
        test_directed_path();
        test_full_path();
        test_elapsed_long();
        test_random();
        drain();
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
